// ===== hw/rtl/kti_pkg.sv =====
// ----------------------------------------------------------------------------
// kti_pkg
// Shared constants, codes and address helpers for the keyframe interpolator.
// ----------------------------------------------------------------------------
package kti_pkg;

    localparam int MAX_KEYFRAMES = 64;
    localparam int VERTEX_COUNT  = 3;
    localparam int FRAME_WORDS   = 1 + 4 + 3 * VERTEX_COUNT;
    localparam int COMPONENTS    = 3 * VERTEX_COUNT + 4;
    localparam int COORDS        = 3 * VERTEX_COUNT;

    localparam int FRAME_W = $clog2(MAX_KEYFRAMES);
    localparam int CNT_W   = $clog2(MAX_KEYFRAMES + 1);
    localparam int ADDR_W  = $clog2(MAX_KEYFRAMES * FRAME_WORDS);
    localparam int DEPTH   = MAX_KEYFRAMES * FRAME_WORDS;

    // divider widths: numerator is a 33-bit difference scaled by 2^16
    localparam int NUM_W = 49;
    localparam int DEN_W = 33;

    // request types
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_ACK   = 2'd2;

    // word offsets inside one keyframe
    localparam logic [3:0] W_TIME = 4'd0;

    // store word offset of an output component
    function automatic logic [3:0] comp_word(input logic [3:0] c);
        logic [3:0] w;
        if (c < 4'(COORDS)) begin
            w = c + 4'd5;
        end else begin
            w = c - 4'(COORDS - 1);
        end
        return w;
    endfunction

    // flat store address of one word of one keyframe
    function automatic logic [ADDR_W-1:0] word_addr(input logic [FRAME_W-1:0] f,
                                                   input logic [3:0] w);
        logic [ADDR_W+4:0] a;
        a = (ADDR_W+5)'(f) * (ADDR_W+5)'(FRAME_WORDS) + (ADDR_W+5)'(w);
        return a[ADDR_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/kti_ifs.sv =====
// ----------------------------------------------------------------------------
// kti_ifs
// Channel interfaces: request, result and configuration write.
// ----------------------------------------------------------------------------
interface kti_req_if;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [5:0]          frame_index;
    logic [3:0]          word_index;
    logic signed [31:0]  word_value;
    logic signed [31:0]  query_time;

    modport source (output valid, req_type, frame_index, word_index, word_value,
                    query_time, input ready);
    modport sink   (input valid, req_type, frame_index, word_index, word_value,
                    query_time, output ready);
endinterface

interface kti_rsp_if;
    logic                valid;
    logic                ready;
    logic [3:0]          component_index;
    logic signed [31:0]  component_value;
    logic [1:0]          status;
    logic                last;

    modport source (output valid, component_index, component_value, status, last,
                    input ready);
    modport sink   (input valid, component_index, component_value, status, last,
                    output ready);
endinterface

interface kti_cfg_if;
    logic        valid;
    logic        ready;
    logic [6:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/keyframe_triangle_interpolator.sv =====
// ----------------------------------------------------------------------------
// keyframe_triangle_interpolator
// Keyframe store with linear search, serial divide and per-component blend.
//
//   channel  dir  beat
//   i_req    in   write word or query time
//   o_rsp    out  one component, an ack or an empty-table status
//   i_cfg    in   keyframe count
//
// A write gives one ack beat. A query reads one keyframe time per keyframe
// passed in the search, runs a serial divide, then per component does two
// store reads, a multiply and a blend; with the last keyframe active it skips
// the divide and gives raw words, one store read per component.
// The store is one single-port-read memory with no reset; count resets to 0.
// A stalled result register holds the sequencer; one item is in work at a time.
// ----------------------------------------------------------------------------
module keyframe_triangle_interpolator (
    input  logic     i_clk,
    input  logic     i_rst_n,
    kti_req_if.sink   i_req,
    kti_rsp_if.source o_rsp,
    kti_cfg_if.sink   i_cfg
);

    localparam int FW = kti_pkg::FRAME_W;
    localparam int NW = kti_pkg::CNT_W;

    typedef enum logic [4:0] {
        S_IDLE, S_ACK, S_EMPTY, S_SRD, S_SCHK, S_T0RD, S_T0WAIT, S_DIV,
        S_LRD, S_LWAIT, S_LEMIT, S_CA, S_CB, S_CMUL, S_CV, S_CEMIT
    } t_state;

    t_state             r_state;
    logic [6:0]         r_count;
    logic [NW-1:0]      r_n;
    logic [FW-1:0]      r_a;
    logic [3:0]         r_c;
    logic signed [31:0] r_time;
    logic signed [31:0] r_ts1;
    logic signed [31:0] r_tq;
    logic signed [31:0] r_va;
    logic [63:0]        r_prod;
    logic               r_neg;
    logic signed [31:0] r_val;

    logic               r_out_valid;
    logic [3:0]         r_out_idx;
    logic signed [31:0] r_out_val;
    logic [1:0]         r_out_st;
    logic               r_out_last;

    logic [kti_pkg::ADDR_W-1:0] w_raddr;
    logic [31:0]                w_rdata;
    logic                       w_we;
    logic                       w_out_free;
    logic                       w_emit;
    logic                       w_acc;
    logic [FW-1:0]              w_a1;
    logic [3:0]                 w_cw;
    logic [NW-1:0]              w_n_in;
    logic                       w_div_start;
    logic                       w_div_done;
    logic signed [31:0]         w_quot;
    logic signed [32:0]         w_den;
    logic signed [48:0]         w_num;
    logic signed [32:0]         w_d;
    logic [31:0]                w_md;
    logic [31:0]                w_mt;
    logic signed [49:0]         w_term;
    logic signed [49:0]         w_v;
    logic signed [49:0]         w_vc;
    logic [NW:0]                w_a2;

    assign w_acc      = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_a1       = r_a + FW'(1);
    assign w_a2       = (NW+1)'(r_a) + (NW+1)'(2);
    assign w_cw       = kti_pkg::comp_word(r_c);
    assign w_n_in     = (r_count > 7'(kti_pkg::MAX_KEYFRAMES)) ?
                        NW'(kti_pkg::MAX_KEYFRAMES) : NW'(r_count);

    // a new result beat loads the result register this cycle
    assign w_emit = w_out_free && (r_state == S_ACK || r_state == S_EMPTY ||
                                   r_state == S_LEMIT || r_state == S_CEMIT);

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg.valid) begin
            r_count <= i_cfg.data;
        end
    end

    // store write on a write beat that lands in range
    assign w_we = w_acc && (i_req.req_type == kti_pkg::REQ_WRITE) &&
                  (32'(i_req.frame_index) < 32'(kti_pkg::MAX_KEYFRAMES)) &&
                  (i_req.word_index < 4'(kti_pkg::FRAME_WORDS));

    // store read address by state
    always_comb begin
        case (r_state)
            S_SRD:   w_raddr = kti_pkg::word_addr(w_a1, kti_pkg::W_TIME);
            S_T0RD:  w_raddr = kti_pkg::word_addr(r_a, kti_pkg::W_TIME);
            S_LRD:   w_raddr = kti_pkg::word_addr(r_a, w_cw);
            S_CA:    w_raddr = kti_pkg::word_addr(r_a, w_cw);
            S_CB:    w_raddr = kti_pkg::word_addr(w_a1, w_cw);
            default: w_raddr = kti_pkg::word_addr(r_a, w_cw);
        endcase
    end

    kti_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (kti_pkg::word_addr(FW'(i_req.frame_index), i_req.word_index)),
        .i_wdata (i_req.word_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // span and scaled offset for t
    assign w_den       = 33'(r_ts1) - 33'(signed'(w_rdata));
    assign w_num       = {33'(r_time) - 33'(signed'(w_rdata)), 16'd0};
    assign w_div_start = (r_state == S_T0WAIT);

    kti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // blend arithmetic
    assign w_d    = 33'(signed'(w_rdata)) - 33'(r_va);
    assign w_md   = w_d[32] ? 32'(-w_d) : 32'(w_d);
    assign w_mt   = r_tq[31] ? 32'(-r_tq) : 32'(r_tq);
    assign w_term = r_neg ? -50'(r_prod[63:16]) : 50'(r_prod[63:16]);
    assign w_v    = 50'(r_va) + w_term;
    assign w_vc   = (r_neg && (r_prod[15:0] != '0) && w_v > 50'sd0) ?
                    w_v - 50'sd1 : w_v;

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && !w_emit) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_time <= i_req.query_time;
                        r_n    <= w_n_in;
                        r_a    <= '0;
                        r_c    <= '0;
                        if (i_req.req_type == kti_pkg::REQ_WRITE) begin
                            r_state <= S_ACK;
                        end else if (w_n_in == '0) begin
                            r_state <= S_EMPTY;
                        end else if (w_n_in == NW'(1)) begin
                            r_state <= S_LRD;
                        end else begin
                            r_state <= S_SRD;
                        end
                    end
                end
                S_ACK, S_EMPTY: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= '0;
                        r_out_val   <= '0;
                        r_out_st    <= (r_state == S_ACK) ? kti_pkg::ST_ACK
                                                          : kti_pkg::ST_EMPTY;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_SRD: r_state <= S_SCHK;
                S_SCHK: begin
                    if (!(r_time < signed'(w_rdata))) begin
                        r_a     <= w_a1;
                        r_state <= (w_a2 < (NW+1)'(r_n)) ? S_SRD : S_LRD;
                    end else begin
                        r_ts1   <= w_rdata;
                        r_state <= S_T0RD;
                    end
                end
                S_T0RD:   r_state <= S_T0WAIT;
                S_T0WAIT: r_state <= S_DIV;
                S_DIV: begin
                    if (w_div_done) begin
                        r_tq    <= w_quot;
                        r_state <= S_CA;
                    end
                end
                // last keyframe active: raw words
                S_LRD:   r_state <= S_LWAIT;
                S_LWAIT: begin
                    r_va    <= w_rdata;
                    r_state <= S_LEMIT;
                end
                S_LEMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_c;
                        r_out_val   <= r_va;
                        r_out_st    <= kti_pkg::ST_OK;
                        r_out_last  <= (r_c == 4'(kti_pkg::COMPONENTS - 1));
                        if (r_c == 4'(kti_pkg::COMPONENTS - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_c     <= r_c + 4'd1;
                            r_state <= S_LRD;
                        end
                    end
                end
                // interpolated components
                S_CA: r_state <= S_CB;
                S_CB: begin
                    r_va    <= w_rdata;
                    r_state <= S_CMUL;
                end
                S_CMUL: begin
                    r_prod  <= 64'(w_md) * 64'(w_mt);
                    r_neg   <= w_d[32] != r_tq[31];
                    r_state <= S_CV;
                end
                S_CV: begin
                    if (r_c < 4'(kti_pkg::COORDS)) begin
                        if (w_v > 50'sd2147483647) begin
                            r_val <= 32'sh7FFF_FFFF;
                        end else if (w_v < -50'sd2147483648) begin
                            r_val <= 32'sh8000_0000;
                        end else begin
                            r_val <= 32'(w_v);
                        end
                    end else begin
                        if (w_vc < 50'sd0) begin
                            r_val <= '0;
                        end else if (w_vc > 50'sd255) begin
                            r_val <= 32'sd255;
                        end else begin
                            r_val <= 32'(w_vc);
                        end
                    end
                    r_state <= S_CEMIT;
                end
                S_CEMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_c;
                        r_out_val   <= r_val;
                        r_out_st    <= kti_pkg::ST_OK;
                        r_out_last  <= (r_c == 4'(kti_pkg::COMPONENTS - 1));
                        if (r_c == 4'(kti_pkg::COMPONENTS - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_c     <= r_c + 4'd1;
                            r_state <= S_CA;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.component_index = r_out_idx;
    assign o_rsp.component_value = r_out_val;
    assign o_rsp.status          = r_out_st;
    assign o_rsp.last            = r_out_last;

endmodule

// ===== hw/rtl/kti_store.sv =====
// ----------------------------------------------------------------------------
// kti_store
// Keyframe word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kti_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [kti_pkg::ADDR_W-1:0]  i_waddr,
    input  logic [31:0]                 i_wdata,
    input  logic [kti_pkg::ADDR_W-1:0]  i_raddr,
    output logic [31:0]                 o_rdata
);

    logic [31:0] r_mem [kti_pkg::DEPTH];
    logic [31:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/kti_div.sv =====
// ----------------------------------------------------------------------------
// kti_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero,
// quotient saturated to 32 bits. A zero divisor gives zero.
// ----------------------------------------------------------------------------
module kti_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [kti_pkg::NUM_W-1:0]  i_num,
    input  logic signed [kti_pkg::DEN_W-1:0]  i_den,
    output logic                              o_done,
    output logic signed [31:0]                o_quot
);

    localparam int NW = kti_pkg::NUM_W;
    localparam int DW = kti_pkg::DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [NW-1:0]     r_q;
    logic [DW:0]       r_rem;
    logic [DW-1:0]     r_den;
    logic              r_neg;
    logic              r_zero;
    logic signed [31:0] r_quot;

    logic [DW:0]       w_trial;
    logic [DW:0]       w_diff;
    logic [NW-1:0]     w_q_next;
    logic [NW-1:0]     w_num_mag;
    logic [DW-1:0]     w_den_mag;

    assign w_num_mag = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
    assign w_den_mag = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);

    // one restoring step
    assign w_trial  = {r_rem[DW-1:0], r_q[NW-1]};
    assign w_diff   = w_trial - {1'b0, r_den};
    assign w_q_next = {r_q[NW-2:0], ~w_diff[DW]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_q    <= w_num_mag;
                r_rem  <= '0;
                r_den  <= w_den_mag;
                r_neg  <= i_num[NW-1] ^ i_den[DW-1];
                r_zero <= (i_den == '0);
            end else if (r_busy) begin
                r_q   <= w_q_next;
                r_rem <= w_diff[DW] ? w_trial : w_diff;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // sign and saturation after the last step
    always_ff @(posedge i_clk) begin
        if (r_busy && r_cnt == CW'(1)) begin
            if (r_zero) begin
                r_quot <= '0;
            end else if (!r_neg) begin
                r_quot <= (w_q_next > NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                        : 32'(w_q_next);
            end else begin
                r_quot <= (w_q_next > NW'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                         : 32'(-w_q_next);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/kti_checker.sv =====
// ----------------------------------------------------------------------------
// kti_checker
// Port-level checks for the keyframe interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module kti_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [3:0]  i_rsp_idx,
    input logic [31:0] i_rsp_val,
    input logic [1:0]  i_rsp_st,
    input logic        i_rsp_last
);

    // a stalled result beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_val)
        && $stable(i_rsp_idx) && $stable(i_rsp_st) && $stable(i_rsp_last))
        else $error("result beat changed while stalled");

    // one item in work at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    // ack and empty beats are single, zero beats
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_st == kti_pkg::ST_ACK || i_rsp_st == kti_pkg::ST_EMPTY)
        |-> i_rsp_last && i_rsp_idx == 4'd0 && i_rsp_val == 32'd0)
        else $error("bad ack or empty beat");

    // component beats end on the final component
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_st == kti_pkg::ST_OK
        |-> i_rsp_last == (i_rsp_idx == 4'(kti_pkg::COMPONENTS - 1)))
        else $error("last flag on wrong component");

endmodule

bind keyframe_triangle_interpolator kti_checker u_kti_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_idx   (o_rsp.component_index),
    .i_rsp_val   (o_rsp.component_value),
    .i_rsp_st    (o_rsp.status),
    .i_rsp_last  (o_rsp.last)
);
